>>> hw/rtl/cts_pkg.sv
`default_nettype none

package cts_pkg;

    localparam int HIST_DEPTH = 5;

    typedef enum logic [2:0] {
        ST_RUNNING       = 3'd0,
        ST_IN_WINDOW     = 3'd1,
        ST_OSCILLATION   = 3'd2,
        ST_RETRIES_SPENT = 3'd3,
        ST_DISTANCE_ERR  = 3'd4,
        ST_IDLE_IGNORED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_TARGET_MV    = 2'd0,
        CFG_WINDOW_MV    = 2'd1,
        CFG_MAX_DISTANCE = 2'd2,
        CFG_MAX_RETRIES  = 2'd3
    } t_cfg_index;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic signed [14:0] TARGET_MV_RST    = 15'sd0;
    localparam logic        [13:0] WINDOW_MV_RST    = 14'd250;
    localparam logic        [11:0] MAX_DISTANCE_RST = 12'd50;
    localparam logic        [7:0]  MAX_RETRIES_RST  = 8'd50;

    typedef struct packed {
        logic signed [14:0] target_mv;
        logic        [13:0] window_mv;
        logic        [11:0] max_distance;
        logic        [7:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic        write_tune;
        logic [11:0] tune_value;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/cts_core.sv
`default_nettype none

module cts_core #(
    parameter int TUNE_MAX = 4095
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire                  i_func,
    input  wire  [11:0]          i_start_tune,
    input  wire  signed [14:0]   i_sample_mv,
    input  wire  cts_pkg::t_cfg  i_cfg,
    output cts_pkg::t_result     o_res
);
    import cts_pkg::*;

    // history holds start values (12 bits) and in-range trial values
    localparam int HIST_W = (TUNE_MAX > 4095) ? 13 : 12;
    localparam logic [16:0] TMAX = 17'(TUNE_MAX);

    logic                     r_running, n_running;
    logic [11:0]              r_start, n_start;
    logic signed [13:0]       r_trial, n_trial;
    logic [HIST_W-1:0]        r_hist [HIST_DEPTH];
    logic [HIST_W-1:0]        n_hist [HIST_DEPTH];
    logic [2:0]               r_hist_cnt, n_hist_cnt;
    logic [7:0]               r_retries, n_retries;

    logic signed [16:0]       lo, hi, s_ext;
    logic                     in_win, osc, above, too_far, in_range;
    logic [7:0]               ret_dec;
    logic signed [13:0]       trial_step;
    logic signed [14:0]       delta;
    logic [14:0]              delta_abs;
    logic [HIST_W-1:0]        push_val;

    always_comb begin
        s_ext      = {{2{i_sample_mv[14]}}, i_sample_mv};
        lo         = {{2{i_cfg.target_mv[14]}}, i_cfg.target_mv} - {3'b000, i_cfg.window_mv};
        hi         = {{2{i_cfg.target_mv[14]}}, i_cfg.target_mv} + {3'b000, i_cfg.window_mv};
        in_win     = (s_ext >= lo) && (s_ext <= hi);
        osc        = (r_hist_cnt == 3'(HIST_DEPTH)) && (r_hist[0] == r_hist[2])
                     && (r_hist[2] == r_hist[4]);
        ret_dec    = (r_retries != 8'd0) ? r_retries - 8'd1 : 8'd0;
        above      = i_sample_mv > i_cfg.target_mv;
        trial_step = above ? r_trial + 14'sd1 : r_trial - 14'sd1;
        delta      = {trial_step[13], trial_step} - $signed({3'b000, r_start});
        delta_abs  = delta[14] ? 15'(-delta) : 15'(delta);
        too_far    = delta_abs > {3'b000, i_cfg.max_distance};
        in_range   = !trial_step[13] && ({4'b0000, trial_step[12:0]} <= TMAX);
        push_val   = trial_step[HIST_W-1:0];
    end

    // next state
    always_comb begin
        n_running  = r_running;
        n_start    = r_start;
        n_trial    = r_trial;
        n_hist     = r_hist;
        n_hist_cnt = r_hist_cnt;
        n_retries  = r_retries;
        if (i_func == FUNC_START) begin
            n_running  = 1'b1;
            n_start    = i_start_tune;
            n_trial    = $signed({2'b00, i_start_tune});
            for (int i = 0; i < HIST_DEPTH; i++) begin
                n_hist[i] = '0;
            end
            n_hist[0]  = HIST_W'(i_start_tune);
            n_hist_cnt = 3'd1;
            n_retries  = i_cfg.max_retries;
        end else if (r_running) begin
            if (in_win || osc) begin
                n_running = 1'b0;
            end else begin
                n_retries = ret_dec;
                if (ret_dec == 8'd0) begin
                    n_running = 1'b0;
                end else begin
                    n_trial = trial_step;
                    if (too_far) begin
                        n_running = 1'b0;
                    end else if (in_range) begin
                        // fill in order, then shift out the oldest
                        for (int i = 0; i < HIST_DEPTH; i++) begin
                            if (r_hist_cnt < 3'(HIST_DEPTH)) begin
                                if (r_hist_cnt == 3'(i)) n_hist[i] = push_val;
                            end else if (i < HIST_DEPTH - 1) begin
                                n_hist[i] = r_hist[i+1];
                            end else begin
                                n_hist[i] = push_val;
                            end
                        end
                        if (r_hist_cnt < 3'(HIST_DEPTH)) n_hist_cnt = r_hist_cnt + 3'd1;
                    end
                end
            end
        end
    end

    // result word
    always_comb begin
        o_res.write_tune = 1'b0;
        o_res.tune_value = 12'd0;
        o_res.status     = ST_RUNNING;
        if (i_func == FUNC_START) begin
            o_res.write_tune = 1'b1;
            o_res.tune_value = i_start_tune;
        end else if (!r_running) begin
            o_res.status = ST_IDLE_IGNORED;
        end else if (in_win) begin
            o_res.status = ST_IN_WINDOW;
        end else if (osc) begin
            o_res.status = ST_OSCILLATION;
        end else if (ret_dec == 8'd0) begin
            o_res.status = ST_RETRIES_SPENT;
        end else if (too_far) begin
            o_res.status = ST_DISTANCE_ERR;
        end else if (in_range) begin
            o_res.write_tune = 1'b1;
            o_res.tune_value = trial_step[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_hist_cnt <= 3'd0;
            r_retries  <= 8'd0;
        end else if (i_fire) begin
            r_running  <= n_running;
            r_hist_cnt <= n_hist_cnt;
            r_retries  <= n_retries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_start <= n_start;
            r_trial <= n_trial;
            r_hist  <= n_hist;
        end
    end

`ifndef ASSERT_OFF
    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_func == FUNC_START) |=> (r_running && r_hist_cnt == 3'd1))
        else $error("start did not arm the run");
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.status != ST_RUNNING) |=> !r_running)
        else $error("run still active after a finishing word");
    a_hist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist_cnt <= 3'(HIST_DEPTH))
        else $error("history count past depth");
    a_write_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.write_tune |-> (o_res.status == ST_RUNNING))
        else $error("tune write with a finishing status");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/coarse_tune_step_search.sv
`default_nettype none

// Coarse tune step search. Send a start word (tuser 0) with the current tune value to
// arm a run, then one sample word (tuser 1) per measurement; every input word yields
// exactly one result word. A word is taken each cycle when the output side keeps up;
// a word waits in the input register until the core takes it, its result word is then
// registered and held in the result register until taken. The run state updates at the
// same edge as the result word is registered, so consecutive samples see each other's
// effect. Write the configuration registers only while no words are in flight.
module coarse_tune_step_search #(
    parameter int TUNE_MAX = 4095
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave side
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [31:0]  s_axis_tdata,   // start_tune[11:0], sample_mv[26:12], zero fill
    input  wire          s_axis_tuser,   // func
    // master side
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // write_tune[0], tune_value[12:1], status[15:13]
    // configuration
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [14:0]  i_cfg_data
);
    import cts_pkg::*;

    logic               r_in_valid;
    logic               r_func;
    logic [11:0]        r_start_tune;
    logic signed [14:0] r_sample_mv;
    logic               r_out_valid;
    t_result            r_out;
    t_result            core_res;
    t_cfg               r_cfg;
    logic               fire;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.status, r_out.tune_value, r_out.write_tune};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_mv    <= TARGET_MV_RST;
            r_cfg.window_mv    <= WINDOW_MV_RST;
            r_cfg.max_distance <= MAX_DISTANCE_RST;
            r_cfg.max_retries  <= MAX_RETRIES_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TARGET_MV:    r_cfg.target_mv    <= $signed(i_cfg_data);
                CFG_WINDOW_MV:    r_cfg.window_mv    <= i_cfg_data[13:0];
                CFG_MAX_DISTANCE: r_cfg.max_distance <= i_cfg_data[11:0];
                CFG_MAX_RETRIES:  r_cfg.max_retries  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func       <= s_axis_tuser;
            r_start_tune <= s_axis_tdata[11:0];
            r_sample_mv  <= $signed(s_axis_tdata[26:12]);
        end
    end

    cts_core #(
        .TUNE_MAX (TUNE_MAX)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_func       (r_func),
        .i_start_tune (r_start_tune),
        .i_sample_mv  (r_sample_mv),
        .i_cfg        (r_cfg),
        .o_res        (core_res)
    );

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_res;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_coarse_tune_step_search.sv
`default_nettype none

module tb_coarse_tune_step_search;

    import cts_pkg::*;

    localparam int TUNE_LIMIT = 4095;

    typedef struct packed {
        logic        func;
        logic [11:0] start_tune;
        logic [14:0] sample_mv;
    } t_search_word;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;   // start_tune[11:0], sample_mv[26:12], zero fill
    logic         s_axis_tuser = 1'b0; // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;        // write_tune[0], tune_value[12:1], status[15:13]
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [14:0]  i_cfg_data = '0;

    coarse_tune_step_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the configuration registers
    logic signed [14:0] cfg_target   = TARGET_MV_RST;
    logic        [13:0] cfg_window   = WINDOW_MV_RST;
    logic        [11:0] cfg_distance = MAX_DISTANCE_RST;
    logic        [7:0]  cfg_retries  = MAX_RETRIES_RST;

    // predicted search state
    logic               run_active = 1'b0;
    logic        [11:0] run_base = '0;
    logic signed [13:0] run_trial = '0;
    logic        [11:0] hist [HIST_DEPTH] = '{default: 12'd0};
    logic        [2:0]  hist_cnt = '0;
    logic        [7:0]  retries_left = '0;

    t_search_word pending_words[$];
    t_result      expected_results[$];

    int          bad_words = 0;
    int          src_idle_pct = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] sink_pattern = 16'hFFFF;
    logic [3:0]  sink_pos = '0;

    function automatic t_result tune_search_step(input t_search_word w);
        t_result r;
        int      s, tgt, lo, hi, span;
        r = '{write_tune: 1'b0, tune_value: 12'd0, status: ST_RUNNING};
        s = $signed(w.sample_mv);
        tgt = $signed(cfg_target);
        if (w.func == FUNC_START) begin
            run_active = 1'b1;
            run_base = w.start_tune;
            run_trial = w.start_tune;
            hist = '{default: 12'd0};
            hist[0] = w.start_tune;
            hist_cnt = 3'd1;
            retries_left = cfg_retries;
            r.write_tune = 1'b1;
            r.tune_value = w.start_tune;
        end else if (!run_active) begin
            r.status = ST_IDLE_IGNORED;
        end else begin
            lo = tgt - int'(cfg_window);
            hi = tgt + int'(cfg_window);
            if (s >= lo && s <= hi) begin
                run_active = 1'b0;
                r.status = ST_IN_WINDOW;
            end else if (hist_cnt == HIST_DEPTH && hist[0] == hist[2] && hist[2] == hist[4]) begin
                run_active = 1'b0;
                r.status = ST_OSCILLATION;
            end else begin
                if (retries_left != 0)
                    retries_left = retries_left - 1;
                if (retries_left == 0) begin
                    run_active = 1'b0;
                    r.status = ST_RETRIES_SPENT;
                end else begin
                    if (s > tgt)
                        run_trial = run_trial + 1;
                    else
                        run_trial = run_trial - 1;
                    span = int'(run_trial) - int'(run_base);
                    if (span < 0)
                        span = -span;
                    if (span > int'(cfg_distance)) begin
                        run_active = 1'b0;
                        r.status = ST_DISTANCE_ERR;
                    end else if (run_trial >= 0 && run_trial <= TUNE_LIMIT) begin
                        // shift out the oldest entry once the history is full
                        if (hist_cnt < HIST_DEPTH) begin
                            hist[hist_cnt] = run_trial[11:0];
                            hist_cnt = hist_cnt + 1;
                        end else begin
                            for (int i = 0; i < HIST_DEPTH - 1; i++)
                                hist[i] = hist[i + 1];
                            hist[HIST_DEPTH - 1] = run_trial[11:0];
                        end
                        r.write_tune = 1'b1;
                        r.tune_value = run_trial[11:0];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void queue_start(input logic [11:0] tv);
        t_search_word w;
        w = '{func: FUNC_START, start_tune: tv, sample_mv: 15'($urandom)};
        pending_words = {pending_words, w};
    endfunction

    function automatic void queue_sample(input int mv);
        t_search_word w;
        w = '{func: FUNC_SAMPLE, start_tune: 12'($urandom), sample_mv: 15'(mv)};
        pending_words = {pending_words, w};
    endfunction

    // kind: 0 inside the window, 1 above it, 2 below it, else any 15-bit value
    function automatic int pick_mv(input int kind);
        int lo, hi;
        lo = $signed(cfg_target) - int'(cfg_window);
        hi = $signed(cfg_target) + int'(cfg_window);
        if (lo < -10000)
            lo = -10000;
        if (hi > 10000)
            hi = 10000;
        case (kind)
            0: begin
                if ($urandom_range(0, 3) == 0)
                    return ($urandom_range(0, 1) != 0) ? lo : hi;
                return lo + int'($urandom_range(0, hi - lo));
            end
            1: if (hi < 10000) begin
                if ($urandom_range(0, 1) != 0)
                    return hi + 1;
                return hi + 1 + int'($urandom_range(0, 9999 - hi));
            end
            2: if (lo > -10000) begin
                if ($urandom_range(0, 1) != 0)
                    return lo - 1;
                return -10000 + int'($urandom_range(0, lo + 9999));
            end
            default: ;
        endcase
        return int'($urandom_range(0, 32767)) - 16384;
    endfunction

    // one start word and a run of samples; returns the number of words queued
    function automatic int queue_run();
        int          mode, len, dir, kind, i;
        logic [11:0] tv;
        case ($urandom_range(0, 7))
            0: tv = 12'd0;
            1: tv = 12'hFFF;
            2: tv = 12'($urandom_range(0, 3));
            3: tv = 12'hFFF - 12'($urandom_range(0, 3));
            default: tv = 12'($urandom);
        endcase
        queue_start(tv);
        mode = $urandom_range(0, 3);
        len = $urandom_range(1, 16);
        dir = $urandom_range(1, 2);
        for (i = 0; i < len; i++) begin
            case (mode)
                0: kind = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
                1: kind = (i % 2 == 0) ? dir : 3 - dir;
                2: kind = dir;
                default: kind = (i == len - 1) ? 0 : $urandom_range(1, 2);
            endcase
            if ($urandom_range(0, 29) == 0)
                kind = 3;
            queue_sample(pick_mv(kind));
        end
        return len + 1;
    endfunction

    task automatic flag_error(input string what);
        bad_words++;
        if (bad_words <= 10)
            $display("%0t: %s", $time, what);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [14:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET_MV:    cfg_target = val;
            CFG_WINDOW_MV:    cfg_window = val[13:0];
            CFG_MAX_DISTANCE: cfg_distance = val[11:0];
            CFG_MAX_RETRIES:  cfg_retries = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // source: present words from the pending queue in bursts
    always @(posedge i_clk) begin : source
        logic    taken;
        t_result exp_res;
        taken = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (taken) begin
                exp_res = tune_search_step(pending_words[0]);
                expected_results = {expected_results, exp_res};
                void'(pending_words.pop_front());
            end
            if (s_axis_tvalid && !taken) begin
                // hold the word until accepted
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_words[0].func;
                s_axis_tdata  <= {5'd0, pending_words[0].sample_mv, pending_words[0].start_tune};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 99) < src_idle_pct) ? $urandom_range(1, 6) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink: stall on a rotating pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_pos <= '0;
        end else begin
            m_axis_tready <= sink_pattern[sink_pos];
            sink_pos <= sink_pos + 4'd1;
        end
    end

    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                flag_error($sformatf("unexpected result word %h", m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[0] !== want.write_tune || m_axis_tdata[12:1] !== want.tune_value
                        || m_axis_tdata[15:13] !== want.status)
                    flag_error($sformatf(
                        "result mismatch: want wr=%0d val=%0d st=%0d, got wr=%0d val=%0d st=%0d",
                        want.write_tune, want.tune_value, want.status,
                        m_axis_tdata[0], m_axis_tdata[12:1], m_axis_tdata[15:13]));
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_coarse_tune_step_search: done, errors");
        $finish;
    end

    initial begin : stimulus
        int ph, run_words;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: idle sample, range edges, window edge, oscillation, restart
        @(negedge i_clk);
        queue_sample(10000);
        queue_start(12'd0);
        queue_sample(-10000);
        queue_sample(-251);
        queue_sample(0);
        queue_start(12'd4095);
        queue_sample(10000);
        queue_sample(250);
        queue_start(12'd2048);
        queue_sample(-251);
        queue_sample(251);
        queue_sample(-251);
        queue_sample(251);
        queue_sample(9999);
        queue_start(12'h555);
        queue_start(12'hAAA);
        queue_sample(-250);
        queue_sample(-16384);
        drain();

        // zero window, zero distance, zero retry budget
        write_reg(CFG_TARGET_MV, 15'(-10000));
        write_reg(CFG_WINDOW_MV, 15'd0);
        write_reg(CFG_MAX_DISTANCE, 15'd0);
        write_reg(CFG_MAX_RETRIES, 15'd0);
        @(negedge i_clk);
        queue_start(12'd100);
        queue_sample(-10000);
        queue_start(12'd100);
        queue_sample(10000);
        drain();
        write_reg(CFG_MAX_RETRIES, 15'd255);
        @(negedge i_clk);
        queue_start(12'd4095);
        queue_sample(10000);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_TARGET_MV, 15'd0);
                    write_reg(CFG_WINDOW_MV, 15'd100);
                    write_reg(CFG_MAX_DISTANCE, 15'd3);
                    write_reg(CFG_MAX_RETRIES, 15'd255);
                end
                1: begin
                    write_reg(CFG_TARGET_MV, 15'd10000);
                    write_reg(CFG_WINDOW_MV, 15'd0);
                    write_reg(CFG_MAX_DISTANCE, 15'd4095);
                    write_reg(CFG_MAX_RETRIES, 15'd1);
                end
                2: begin
                    write_reg(CFG_TARGET_MV, 15'(-4000));
                    write_reg(CFG_WINDOW_MV, 15'd10000);
                    write_reg(CFG_MAX_DISTANCE, 15'd20);
                    write_reg(CFG_MAX_RETRIES, 15'd8);
                end
                4: begin
                    write_reg(CFG_TARGET_MV, 15'd123);
                    write_reg(CFG_WINDOW_MV, 15'd37);
                    write_reg(CFG_MAX_DISTANCE, 15'd6);
                    write_reg(CFG_MAX_RETRIES, 15'd255);
                end
                default: begin
                    write_reg(CFG_TARGET_MV, 15'(int'($urandom_range(0, 20000)) - 10000));
                    write_reg(CFG_WINDOW_MV, 15'($urandom_range(0, 2000)));
                    write_reg(CFG_MAX_DISTANCE, 15'($urandom_range(0, 30)));
                    write_reg(CFG_MAX_RETRIES, 15'($urandom_range(0, 40)));
                end
            endcase
            @(negedge i_clk);
            src_idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 35 : 70;
            sink_pattern = (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            run_words = 0;
            // a run left open by the previous phase continues under the new settings
            if ($urandom_range(0, 1) != 0)
                queue_sample(pick_mv($urandom_range(1, 2)));
            while (run_words < 105) begin
                if ($urandom_range(0, 6) == 0)
                    queue_sample(pick_mv($urandom_range(0, 3)));
                run_words += queue_run();
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (bad_words == 0)
            $display("tb_coarse_tune_step_search: done, clean");
        else
            $display("tb_coarse_tune_step_search: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/cts_pkg.sv
hw/rtl/cts_core.sv
hw/rtl/coarse_tune_step_search.sv
tb/tb_coarse_tune_step_search.sv
